### hdl/button_autorepeat_qualifier_assert.svh
// Assertion helpers for the button autorepeat qualifier.
`ifndef BUTTON_AUTOREPEAT_QUALIFIER_ASSERT_SVH
`define BUTTON_AUTOREPEAT_QUALIFIER_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define BAR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define BAR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/bar_pkg.sv
package bar_pkg;

  // Repeat delay table length and derived limits
  localparam int unsigned RepeatTableLen = 11;
  localparam int unsigned RepeatLenClamped =
    (RepeatTableLen < 1) ? 1 : ((RepeatTableLen > 16) ? 16 : RepeatTableLen);
  localparam logic [3:0] LastStep = 4'(RepeatLenClamped - 1);

  localparam int unsigned TimeW    = 32;
  localparam int unsigned SampleW  = 10;
  localparam int unsigned ReleaseW = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned DelayW   = 9;

  localparam logic [SampleW-1:0]  ThresholdReset = 10'd1020;
  localparam logic [ReleaseW-1:0] ReleaseReset   = 16'd500;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SELECT_THRESHOLD  = 2'd0,
    CFG_SELECT_RELEASE_MS = 2'd1
  } bar_cfg_idx_e;

  // Lane status toward the merge stage
  typedef struct packed {
    logic fire;
    logic held;
  } bar_lane_t;

  // One result transaction
  typedef struct packed {
    logic up;
    logic down;
    logic left;
    logic right;
    logic sel;
  } bar_evt_t;

  // Shrinking repeat delay per step
  function automatic logic [DelayW-1:0] repeat_delay(input logic [3:0] step);
    logic [DelayW-1:0] d;
    case (step)
      4'd0, 4'd1:               d = 9'd500;
      4'd2, 4'd3, 4'd4, 4'd5:   d = 9'd250;
      4'd6, 4'd7, 4'd8, 4'd9:   d = 9'd125;
      default:                  d = 9'd75;
    endcase
    return d;
  endfunction

endpackage

### hdl/bar_dir_lane.sv
module bar_dir_lane
  import bar_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [TimeW-1:0] now_ms_i,
  input  logic             level_i,
  output bar_lane_t        status_o
);

  logic             pressed_q, pressed_d;
  logic [TimeW-1:0] stamp_q, stamp_d;
  logic [3:0]       step_q, step_d;
  logic [3:0]       step_cl;
  logic [TimeW-1:0] elapsed;
  logic             fire;

  // Evaluate press, repeat and release for this button
  always_comb begin
    step_cl   = (step_q > LastStep) ? LastStep : step_q;
    elapsed   = now_ms_i - stamp_q;
    pressed_d = pressed_q;
    stamp_d   = stamp_q;
    step_d    = step_q;
    fire      = 1'b0;
    if (!level_i) begin
      pressed_d = 1'b0;
    end else if (!pressed_q) begin
      pressed_d = 1'b1;
      stamp_d   = now_ms_i;
      step_d    = '0;
      fire      = 1'b1;
    end else if (elapsed >= TimeW'(repeat_delay(step_cl))) begin
      stamp_d = now_ms_i;
      step_d  = (step_cl >= LastStep) ? LastStep : step_cl + 4'd1;
      fire    = 1'b1;
    end
  end

  assign status_o.fire = fire;
  assign status_o.held = pressed_d;

  // Advance lane state on each input transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q <= 1'b0;
      stamp_q   <= '0;
      step_q    <= '0;
    end else if (accept_i) begin
      pressed_q <= pressed_d;
      stamp_q   <= stamp_d;
      step_q    <= step_d;
    end
  end

endmodule

### hdl/bar_sel_lane.sv
module bar_sel_lane
  import bar_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [TimeW-1:0]    now_ms_i,
  input  logic [SampleW-1:0]  sample_i,
  input  logic [SampleW-1:0]  threshold_i,
  input  logic [ReleaseW-1:0] release_ms_i,
  output bar_lane_t           status_o
);

  logic             pressed_q, pressed_d;
  logic [TimeW-1:0] stamp_q, stamp_d;
  logic [TimeW-1:0] elapsed;
  logic             fire;

  // Fire once per press, re-arm when below threshold once the release time has passed since the press
  always_comb begin
    elapsed   = now_ms_i - stamp_q;
    pressed_d = pressed_q;
    stamp_d   = stamp_q;
    fire      = 1'b0;
    if (sample_i >= threshold_i) begin
      if (!pressed_q) begin
        pressed_d = 1'b1;
        stamp_d   = now_ms_i;
        fire      = 1'b1;
      end
    end else if (elapsed >= TimeW'(release_ms_i)) begin
      pressed_d = 1'b0;
    end
  end

  assign status_o.fire = fire;
  assign status_o.held = pressed_d;

  // Advance select state on each input transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q <= 1'b0;
      stamp_q   <= '0;
    end else if (accept_i) begin
      pressed_q <= pressed_d;
      stamp_q   <= stamp_d;
    end
  end

endmodule

### hdl/bar_merge.sv
module bar_merge
  import bar_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  bar_lane_t up_i,
  input  bar_lane_t down_i,
  input  bar_lane_t left_i,
  input  bar_lane_t right_i,
  input  bar_lane_t sel_i,
  input  logic      out_ready_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  output bar_evt_t  out_evt_o
);

  bar_evt_t evt;
  bar_evt_t out_q, skid_q;
  logic     out_valid_q, skid_valid_q;
  logic     take;

  // Combine lanes; drop up while down is held after this transaction
  always_comb begin
    evt.up    = up_i.fire & ~down_i.held;
    evt.down  = down_i.fire;
    evt.left  = left_i.fire;
    evt.right = right_i.fire;
    evt.sel   = sel_i.fire;
  end

  assign take        = out_valid_q & out_ready_i;
  assign in_ready_o  = ~skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_evt_o   = out_q;

  // Output register and skid valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (take) begin
      if (skid_valid_q) begin
        skid_valid_q <= accept_i;
      end else begin
        out_valid_q <= accept_i;
      end
    end else if (accept_i) begin
      if (out_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (take) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (accept_i) begin
          skid_q <= evt;
        end
      end else if (accept_i) begin
        out_q <= evt;
      end
    end else if (accept_i) begin
      if (out_valid_q) begin
        skid_q <= evt;
      end else begin
        out_q <= evt;
      end
    end
  end

endmodule

### hdl/button_autorepeat_qualifier.sv
// Button press qualifier with accelerating autorepeat.
// Input channel (in_valid_i/in_ready_o): one sample per transaction carrying
// the millisecond time, four direction levels and the analog select reading.
// Output channel (out_valid_o/out_ready_i): one result per input transaction,
// five event bits, in input order.
// Config channel (cfg_valid_i/cfg_ready_o): index 0 select threshold,
// index 1 select release time in ms; other indexes are ignored. Always ready.
// Each result is registered in the output buffer. Throughput: one transaction
// per cycle while in_ready_o is high; five lanes (four direction, one select)
// evaluate in parallel and a merge stage applies the up/down mask.
// Stall: a two-entry output buffer (output register plus skid) keeps
// accepting while one result waits; in_ready_o drops only when both entries
// hold results.
// Reset: all press flags, stamps and repeat steps clear, threshold returns
// to 1020 and release time to 500 ms, output buffer empties.
module button_autorepeat_qualifier
  import bar_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [TimeW-1:0]    now_ms_i,
  input  logic                up_level_i,
  input  logic                down_level_i,
  input  logic                left_level_i,
  input  logic                right_level_i,
  input  logic [SampleW-1:0]  select_sample_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                up_event_o,
  output logic                down_event_o,
  output logic                left_event_o,
  output logic                right_event_o,
  output logic                select_event_o
);

  `include "button_autorepeat_qualifier_assert.svh"

  logic [SampleW-1:0]  thresh_q;
  logic [ReleaseW-1:0] release_q;
  logic                accept;
  bar_lane_t           up_st, down_st, left_st, right_st, sel_st;
  bar_evt_t            out_evt;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i & in_ready_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q  <= ThresholdReset;
      release_q <= ReleaseReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (bar_cfg_idx_e'(cfg_index_i))
        CFG_SELECT_THRESHOLD:  thresh_q  <= cfg_data_i[SampleW-1:0];
        CFG_SELECT_RELEASE_MS: release_q <= cfg_data_i[ReleaseW-1:0];
        default: ;
      endcase
    end
  end

  // Direction lanes
  bar_dir_lane u_up (
    .clk_i, .rst_ni, .accept_i(accept), .now_ms_i,
    .level_i(up_level_i), .status_o(up_st)
  );
  bar_dir_lane u_down (
    .clk_i, .rst_ni, .accept_i(accept), .now_ms_i,
    .level_i(down_level_i), .status_o(down_st)
  );
  bar_dir_lane u_left (
    .clk_i, .rst_ni, .accept_i(accept), .now_ms_i,
    .level_i(left_level_i), .status_o(left_st)
  );
  bar_dir_lane u_right (
    .clk_i, .rst_ni, .accept_i(accept), .now_ms_i,
    .level_i(right_level_i), .status_o(right_st)
  );

  // Select lane
  bar_sel_lane u_sel (
    .clk_i, .rst_ni, .accept_i(accept), .now_ms_i,
    .sample_i(select_sample_i), .threshold_i(thresh_q),
    .release_ms_i(release_q), .status_o(sel_st)
  );

  // Merge and output buffering
  bar_merge u_merge (
    .clk_i, .rst_ni, .accept_i(accept),
    .up_i(up_st), .down_i(down_st), .left_i(left_st),
    .right_i(right_st), .sel_i(sel_st),
    .out_ready_i, .in_ready_o, .out_valid_o, .out_evt_o(out_evt)
  );

  assign up_event_o     = out_evt.up;
  assign down_event_o   = out_evt.down;
  assign left_event_o   = out_evt.left;
  assign right_event_o  = out_evt.right;
  assign select_event_o = out_evt.sel;

  // Checks
  `BAR_ASSERT(a_stall_needs_result, clk_i, rst_ni, !in_ready_o |-> out_valid_o, "input stalled with empty output")
  `BAR_ASSERT(a_left_needs_level, clk_i, rst_ni, accept && !left_level_i |-> !left_st.fire, "left event while released")
  `BAR_ASSERT(a_sel_needs_level, clk_i, rst_ni, accept && (select_sample_i < thresh_q) |-> !sel_st.fire, "select event below threshold")

endmodule
